>>> sv/dcsd_pkg.sv
package dcsd_pkg;

	// Command bytes seen in text mode
	localparam logic [7:0] OPC_ENTER_BITMAP = 8'd3;
	localparam logic [7:0] OPC_TEXT_CLEAR   = 8'd4;
	localparam logic [7:0] OPC_BACKSPACE    = 8'd8;

	// Command bytes seen in bitmap mode with nothing pending
	localparam logic [7:0] OPC_PIXEL        = 8'd0;
	localparam logic [7:0] OPC_TRIANGLE     = 8'd5;
	localparam logic [7:0] OPC_BM_CLEAR     = 8'd4;
	localparam logic [7:0] OPC_ENTER_TEXT   = 8'd1;

	// Argument bytes gathered before the final colour byte
	localparam int          ARG_STORE_DEPTH = 12;
	localparam logic [3:0]  PIXEL_ARGS      = 4'd4;
	localparam logic [3:0]  TRI_ARGS        = 4'd12;

	// Token queue between front and back
	localparam int QPTR_W      = 2;
	localparam int QUEUE_DEPTH = 1 << QPTR_W;
	localparam int QCNT_W      = QPTR_W + 1;

	typedef enum logic [2:0] {
		EV_CHAR         = 3'd0,
		EV_TEXT_CLEAR   = 3'd1,
		EV_BACKSPACE    = 3'd2,
		EV_ENTER_BITMAP = 3'd3,
		EV_PIXEL        = 3'd4,
		EV_TRIANGLE     = 3'd5,
		EV_BM_CLEAR     = 3'd6,
		EV_ENTER_TEXT   = 3'd7
	} event_kind_t;

	typedef enum logic {
		TOK_EVENT = 1'b0,
		TOK_ARG   = 1'b1
	} tok_op_t;

	// Front sequencer: mode plus pending command
	typedef enum logic [2:0] {
		ST_TEXT,
		ST_BM_IDLE,
		ST_PIXEL,
		ST_TRI,
		ST_CLEAR
	} fstate_t;

	// One classified byte: either an argument to store or a finished event
	typedef struct packed {
		tok_op_t     op;
		event_kind_t kind;
		logic [7:0]  data;
		logic [3:0]  idx;
	} token_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  char_code;
		logic [15:0] x_first;
		logic [15:0] y_first;
		logic [15:0] x_second;
		logic [15:0] y_second;
		logic [15:0] x_third;
		logic [15:0] y_third;
		logic [7:0]  draw_color;
	} result_t;

endpackage

>>> sv/dcsd_front.sv
module dcsd_front import dcsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	output logic       tok_push,
	output token_t     tok
);

	fstate_t    state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       tok_valid;

	// Sequencer state and argument counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TEXT;
			cnt_q   <= '0;
		end else if (accept) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_TEXT: begin
				if (data_byte == OPC_ENTER_BITMAP) state_d = ST_BM_IDLE;
			end
			ST_BM_IDLE: begin
				cnt_d = '0;
				if (data_byte == OPC_PIXEL) state_d = ST_PIXEL;
				else if (data_byte == OPC_TRIANGLE) state_d = ST_TRI;
				else if (data_byte == OPC_BM_CLEAR) state_d = ST_CLEAR;
				else if (data_byte == OPC_ENTER_TEXT) state_d = ST_TEXT;
			end
			ST_PIXEL: begin
				if (cnt_q < PIXEL_ARGS) cnt_d = cnt_q + 4'd1;
				else begin
					state_d = ST_BM_IDLE;
					cnt_d   = '0;
				end
			end
			ST_TRI: begin
				if (cnt_q < TRI_ARGS) cnt_d = cnt_q + 4'd1;
				else begin
					state_d = ST_BM_IDLE;
					cnt_d   = '0;
				end
			end
			ST_CLEAR: begin
				state_d = ST_BM_IDLE;
				cnt_d   = '0;
			end
			default: state_d = ST_TEXT;
		endcase
	end

	// Token classification
	always_comb begin
		tok_valid = 1'b0;
		tok.op    = TOK_EVENT;
		tok.kind  = EV_CHAR;
		tok.data  = data_byte;
		tok.idx   = cnt_q;
		unique case (state_q)
			ST_TEXT: begin
				tok_valid = 1'b1;
				case (data_byte)
					OPC_ENTER_BITMAP: tok.kind = EV_ENTER_BITMAP;
					OPC_TEXT_CLEAR:   tok.kind = EV_TEXT_CLEAR;
					OPC_BACKSPACE:    tok.kind = EV_BACKSPACE;
					default:          tok.kind = EV_CHAR;
				endcase
			end
			ST_BM_IDLE: begin
				if (data_byte == OPC_ENTER_TEXT) begin
					tok_valid = 1'b1;
					tok.kind  = EV_ENTER_TEXT;
				end
			end
			ST_PIXEL: begin
				tok_valid = 1'b1;
				if (cnt_q < PIXEL_ARGS) tok.op = TOK_ARG;
				else tok.kind = EV_PIXEL;
			end
			ST_TRI: begin
				tok_valid = 1'b1;
				if (cnt_q < TRI_ARGS) tok.op = TOK_ARG;
				else tok.kind = EV_TRIANGLE;
			end
			ST_CLEAR: begin
				tok_valid = 1'b1;
				tok.kind  = EV_BM_CLEAR;
			end
			default: tok_valid = 1'b0;
		endcase
	end

	assign tok_push = accept & tok_valid;

	// Argument writes always land inside the store
	a_arg_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_push && tok.op == TOK_ARG) |-> (tok.idx < 4'(ARG_STORE_DEPTH)))
		else $error("argument index beyond store");

	// Counter stays clear whenever no command is pending
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEXT || state_q == ST_BM_IDLE) |=> 1'b1 ##0
		($past(state_q) != ST_BM_IDLE || !$past(accept) || cnt_q == '0))
		else $error("argument counter not cleared at command start");

endmodule

>>> sv/dcsd_queue.sv
module dcsd_queue import dcsd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_tok,
	output logic   full,
	input  logic   pop,
	output token_t pop_tok,
	output logic   empty
);

	token_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push, do_pop;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign pop_tok = slot_q[rd_ptr_q];

	// Token storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_tok;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("token queue overfilled");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == cnt_q[QPTR_W-1:0])
		else $error("token queue pointers disagree with count");

endmodule

>>> sv/dcsd_back.sv
module dcsd_back import dcsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tok_avail,
	input  token_t  tok,
	output logic    tok_pop,
	output logic    res_valid,
	output result_t res,
	input  logic    res_pop
);

	logic [7:0] arg_q [ARG_STORE_DEPTH];
	logic       res_valid_q;
	result_t    res_q, res_d;
	logic       out_free, take_event, take_arg;

	assign out_free   = ~res_valid_q | res_pop;
	assign take_arg   = tok_avail & (tok.op == TOK_ARG);
	assign take_event = tok_avail & (tok.op == TOK_EVENT) & out_free;
	assign tok_pop    = take_arg | take_event;

	// Argument store
	always_ff @(posedge clk) begin
		if (take_arg && tok.idx < 4'(ARG_STORE_DEPTH)) arg_q[tok.idx] <= tok.data;
	end

	// Result assembly from event token and stored arguments
	always_comb begin
		res_d            = '0;
		res_d.kind       = tok.kind;
		case (tok.kind)
			EV_CHAR: res_d.char_code = tok.data;
			EV_PIXEL: begin
				res_d.draw_color = tok.data;
				res_d.x_first    = {arg_q[1], arg_q[0]};
				res_d.y_first    = {arg_q[3], arg_q[2]};
			end
			EV_TRIANGLE: begin
				res_d.draw_color = tok.data;
				res_d.x_first    = {arg_q[1], arg_q[0]};
				res_d.y_first    = {arg_q[3], arg_q[2]};
				res_d.x_second   = {arg_q[5], arg_q[4]};
				res_d.y_second   = {arg_q[7], arg_q[6]};
				res_d.x_third    = {arg_q[9], arg_q[8]};
				res_d.y_third    = {arg_q[11], arg_q[10]};
			end
			EV_BM_CLEAR: res_d.draw_color = tok.data;
			default: res_d.char_code = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (take_event) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (take_event) res_valid_q <= 1'b1;
		else if (res_pop) res_valid_q <= 1'b0;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// A waiting result is never overwritten
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_pop) |=> (res_valid_q && $stable(res_q)))
		else $error("pending result lost");

endmodule

>>> sv/display_command_stream_decoder_unit.sv
// Display command stream decoder.
// Input channel: the host presents one command byte on data_byte with push;
// the byte transfers at a clock edge where push is high and full is low.
// Output channel: while empty is low the oldest decoded command sits on
// event_kind .. draw_color; it transfers at an edge where pop is high.
// Text-mode bytes and the enter-text opcode give one result each; pixel,
// triangle and bitmap-clear commands give one result on their colour byte.
// Opcode and argument bytes otherwise give no result.
// A result passes from the byte that completes it through the token queue
// and then the output register before it appears.
// Throughput: one byte per cycle while full is low; the front classifies
// combinationally and the back consumes one token per cycle while free.
// Reset puts the block in text mode with no command pending and both the
// token queue and the output register empty.
// When the receiver stalls, argument tokens ahead of an event are absorbed,
// event tokens back up in the four-entry queue, and full rises once it has filled.
module display_command_stream_decoder_unit import dcsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [7:0]  char_code,
	output logic [15:0] x_first,
	output logic [15:0] y_first,
	output logic [15:0] x_second,
	output logic [15:0] y_second,
	output logic [15:0] x_third,
	output logic [15:0] y_third,
	output logic [7:0]  draw_color
);

	logic    accept, tok_push, q_empty, tok_pop, res_valid;
	token_t  front_tok, q_tok;
	result_t res;

	assign accept = push & ~full;

	dcsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.tok_push  (tok_push),
		.tok       (front_tok)
	);

	dcsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tok_push),
		.push_tok (front_tok),
		.full     (full),
		.pop      (tok_pop),
		.pop_tok  (q_tok),
		.empty    (q_empty)
	);

	dcsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_avail (~q_empty),
		.tok       (q_tok),
		.tok_pop   (tok_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_pop   (pop)
	);

	// Result ports
	assign empty      = ~res_valid;
	assign event_kind = res.kind;
	assign char_code  = res.char_code;
	assign x_first    = res.x_first;
	assign y_first    = res.y_first;
	assign x_second   = res.x_second;
	assign y_second   = res.y_second;
	assign x_third    = res.x_third;
	assign y_third    = res.y_third;
	assign draw_color = res.draw_color;

endmodule
